@@ src/smm_pkg.sv @@
package smm_pkg;

  localparam int DEF_SEGMENTS  = 64;
  localparam int DEF_SEG_WORDS = 256;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_STORE = 2'd1,
    ACT_MAP   = 2'd2,
    ACT_UNMAP = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SEG    = 3'd1,
    ST_BAD_OFFSET = 3'd2,
    ST_NO_ID      = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic fill;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_fill;
    logic fill_last;
  } dp_status_t;

endpackage

@@ src/smm_ctrl.sv @@
module smm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output smm_pkg::ctrl_cmd_t cmd_o,
  input  smm_pkg::dp_status_t sts_i
);
  import smm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_FILL,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval     = (state_q == S_EVAL);
    cmd_o.fill     = (state_q == S_FILL);
    cmd_o.out_load = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= sts_i.need_fill ? S_FILL : S_DONE;
        end
        S_FILL: begin
          if (sts_i.fill_last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("Result became valid outside the hand-off state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> ($past(state_q == S_EVAL) || $past(state_q == S_FILL)))
    else $error("Zero fill entered without a preceding evaluation.");

endmodule

@@ src/smm_datapath.sv @@
module smm_datapath #(
  parameter int SEGMENTS  = smm_pkg::DEF_SEGMENTS,
  parameter int SEG_WORDS = smm_pkg::DEF_SEG_WORDS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smm_pkg::ctrl_cmd_t  cmd_i,
  output smm_pkg::dp_status_t sts_o,
  input  logic [1:0]          action_i,
  input  logic [2:0]          reg_a_i,
  input  logic [2:0]          reg_b_i,
  input  logic [31:0]         val_a_i,
  input  logic [31:0]         val_b_i,
  input  logic [31:0]         val_c_i,
  output logic                write_enable_o,
  output logic [2:0]          write_reg_o,
  output logic [31:0]         write_value_o,
  output logic [2:0]          status_o
);
  import smm_pkg::*;

  localparam int IW    = $clog2(SEGMENTS);
  localparam int OW    = (SEG_WORDS > 1) ? $clog2(SEG_WORDS) : 1;
  localparam int LW    = $clog2(SEG_WORDS + 1);
  localparam int CW    = $clog2(SEGMENTS + 1);
  localparam int WORDS = SEGMENTS * SEG_WORDS;
  localparam int AW    = $clog2(WORDS);
  localparam logic [AW-1:0] SegWordsA = AW'(SEG_WORDS);

  logic [31:0]   word_mem  [WORDS];
  logic [LW:0]   seg_mem   [SEGMENTS];
  logic [IW-1:0] stack_mem [SEGMENTS];

  action_e     act_q;
  logic [2:0]  reg_a_q;
  logic [2:0]  reg_b_q;
  logic [31:0] val_a_q;
  logic [31:0] val_b_q;
  logic [31:0] val_c_q;

  logic [CW-1:0] free_count_q;
  logic [CW-1:0] next_fresh_q;
  logic [LW-1:0] fill_q;
  logic [IW-1:0] map_id_q;
  logic [LW-1:0] map_len_q;

  logic [31:0]   word_rd_q;
  logic [LW:0]   seg_rd_q;
  logic [IW-1:0] stack_rd_q;

  logic        res_we_q;
  logic [2:0]  res_wr_q;
  logic [31:0] res_wv_q;
  status_e     res_st_q;

  logic [31:0]   seg_id;
  logic [31:0]   offset;
  logic [IW-1:0] seg_idx;
  logic [IW-1:0] stack_top;
  logic [AW-1:0] acc_addr;
  logic [AW-1:0] fill_addr;
  logic          seg_ok;
  logic [LW-1:0] seg_len;
  logic          off_ok;
  logic          too_long;
  logic          have_free;
  logic          have_fresh;
  logic [IW-1:0] map_id;
  logic [LW-1:0] map_len;

  logic        ev_we;
  logic [2:0]  ev_wr;
  logic [31:0] ev_wv;
  status_e     ev_st;
  logic        do_store;
  logic        do_map;
  logic        do_unmap;
  logic        from_stack;

  always_comb begin
    case (act_q)
      ACT_LOAD:  seg_id = val_b_q;
      ACT_STORE: seg_id = val_a_q;
      default:   seg_id = val_c_q;
    endcase
  end

  assign offset    = (act_q == ACT_LOAD) ? val_c_q : val_b_q;
  assign seg_idx   = seg_id[IW-1:0];
  assign stack_top = IW'(free_count_q - CW'(1));
  assign acc_addr  = AW'(AW'(seg_idx) * SegWordsA) + AW'(offset[OW-1:0]);
  assign fill_addr = AW'(AW'(map_id_q) * SegWordsA) + AW'(fill_q[OW-1:0]);

  assign seg_len    = seg_rd_q[LW-1:0];
  assign seg_ok     = (seg_id < 32'(SEGMENTS)) && (CW'(seg_idx) < next_fresh_q) &&
                      seg_rd_q[LW];
  assign off_ok     = offset < 32'(seg_len);
  assign too_long   = val_c_q > 32'(SEG_WORDS);
  assign have_free  = (free_count_q != '0);
  assign have_fresh = (next_fresh_q < CW'(SEGMENTS));
  assign map_id     = have_free ? stack_rd_q : next_fresh_q[IW-1:0];
  assign map_len    = val_c_q[LW-1:0];

  always_comb begin
    ev_we      = 1'b0;
    ev_wr      = 3'd0;
    ev_wv      = 32'd0;
    ev_st      = ST_OK;
    do_store   = 1'b0;
    do_map     = 1'b0;
    do_unmap   = 1'b0;
    from_stack = 1'b0;
    case (act_q)
      ACT_LOAD: begin
        if (!seg_ok) begin
          ev_st = ST_BAD_SEG;
        end else if (!off_ok) begin
          ev_st = ST_BAD_OFFSET;
        end else begin
          ev_we = 1'b1;
          ev_wr = reg_a_q;
          ev_wv = word_rd_q;
        end
      end
      ACT_STORE: begin
        if (!seg_ok) begin
          ev_st = ST_BAD_SEG;
        end else if (!off_ok) begin
          ev_st = ST_BAD_OFFSET;
        end else begin
          do_store = 1'b1;
        end
      end
      ACT_MAP: begin
        if (too_long) begin
          ev_st = ST_TOO_LONG;
        end else if (have_free) begin
          do_map     = 1'b1;
          from_stack = 1'b1;
        end else if (have_fresh) begin
          do_map = 1'b1;
        end else begin
          ev_st = ST_NO_ID;
        end
        if (do_map) begin
          ev_we = 1'b1;
          ev_wr = reg_b_q;
          ev_wv = 32'(map_id);
        end
      end
      ACT_UNMAP: begin
        if (!seg_ok) begin
          ev_st = ST_BAD_SEG;
        end else begin
          do_unmap = 1'b1;
        end
      end
      default: begin
        ev_st = ST_OK;
      end
    endcase
  end

  assign sts_o.need_fill = do_map && (map_len != '0);
  assign sts_o.fill_last = (fill_q == LW'(map_len_q - LW'(1)));

  always_ff @(posedge clk_i) begin
    word_rd_q  <= word_mem[acc_addr];
    seg_rd_q   <= seg_mem[seg_idx];
    stack_rd_q <= stack_mem[stack_top];
    if (cmd_i.eval && do_store) begin
      word_mem[acc_addr] <= val_c_q;
    end else if (cmd_i.fill) begin
      word_mem[fill_addr] <= 32'd0;
    end
    if (cmd_i.eval && do_map) begin
      seg_mem[map_id] <= {1'b1, map_len};
    end else if (cmd_i.eval && do_unmap) begin
      seg_mem[seg_idx] <= '0;
    end
    if (cmd_i.eval && do_unmap && (free_count_q < CW'(SEGMENTS))) begin
      stack_mem[free_count_q[IW-1:0]] <= seg_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_e'(action_i);
      reg_a_q <= reg_a_i;
      reg_b_q <= reg_b_i;
      val_a_q <= val_a_i;
      val_b_q <= val_b_i;
      val_c_q <= val_c_i;
    end
    if (cmd_i.eval) begin
      res_we_q  <= ev_we;
      res_wr_q  <= ev_wr;
      res_wv_q  <= ev_wv;
      res_st_q  <= ev_st;
      map_id_q  <= map_id;
      map_len_q <= map_len;
    end
    if (cmd_i.out_load) begin
      write_enable_o <= res_we_q;
      write_reg_o    <= res_wr_q;
      write_value_o  <= res_wv_q;
      status_o       <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q <= '0;
      next_fresh_q <= '0;
      fill_q       <= '0;
    end else begin
      if (cmd_i.eval) begin
        fill_q <= '0;
        if (do_map && from_stack) begin
          free_count_q <= free_count_q - CW'(1);
        end else if (do_map) begin
          next_fresh_q <= next_fresh_q + CW'(1);
        end else if (do_unmap && (free_count_q < CW'(SEGMENTS))) begin
          free_count_q <= free_count_q + CW'(1);
        end
      end else if (cmd_i.fill) begin
        fill_q <= fill_q + LW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= next_fresh_q)
    else $error("More free ids than ids ever handed out.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_fresh_q <= CW'(SEGMENTS))
    else $error("Fresh id counter ran past the segment count.");

endmodule

@@ src/segmented_memory_manager.sv @@
// Segmented memory unit: one load, store, map or unmap transaction is taken at a time, and
// each one yields exactly one result transaction. Load, store, unmap and any map that is
// refused or has length zero pass from acceptance to a valid result through segment
// table and free stack read, evaluation, and hand-off to the output register. A
// successful map of nonzero length also zero-fills the new segment between evaluation and
// hand-off, one word per cycle through the single write port of the word memory. The next
// transaction is accepted as soon as the previous result has moved into the output
// register. A result held in the output register by a stalled receiver delays the
// hand-off of the following one. No clearing pass runs after reset; segment validity is
// tracked by the fresh id counter and the valid bit of each segment table entry.
module segmented_memory_manager #(
  parameter int SEGMENTS  = smm_pkg::DEF_SEGMENTS,
  parameter int SEG_WORDS = smm_pkg::DEF_SEG_WORDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [2:0]  reg_a_i,
  input  logic [2:0]  reg_b_i,
  input  logic [31:0] val_a_i,
  input  logic [31:0] val_b_i,
  input  logic [31:0] val_c_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [2:0]  write_reg_o,
  output logic [31:0] write_value_o,
  output logic [2:0]  status_o
);
  import smm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  smm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  smm_datapath #(
    .SEGMENTS  (SEGMENTS),
    .SEG_WORDS (SEG_WORDS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .reg_a_i        (reg_a_i),
    .reg_b_i        (reg_b_i),
    .val_a_i        (val_a_i),
    .val_b_i        (val_b_i),
    .val_c_i        (val_c_i),
    .write_enable_o (write_enable_o),
    .write_reg_o    (write_reg_o),
    .write_value_o  (write_value_o),
    .status_o       (status_o)
  );

endmodule
